// ----- sv/lcfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcfp_pkg
// Shared types and codes of the light command frame parser.
// ----------------------------------------------------------------------------
package lcfp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned POS_W    = 3;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MARKER     = 2'd0,
    CFG_TYPE_CODE_POWER  = 2'd1,
    CFG_TYPE_CODE_LEVEL  = 2'd2,
    CFG_TYPE_CODE_COLOUR = 2'd3
  } cfg_index_t;

  // Command kind as sent on the result beat
  typedef enum logic [1:0] {
    KIND_POWER  = 2'd0,
    KIND_LEVEL  = 2'd1,
    KIND_COLOUR = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Byte positions inside a frame (the start marker is position 0)
  localparam logic [POS_W-1:0] POS_TYPE     = 3'd1;
  localparam logic [POS_W-1:0] POS_DATA1    = 3'd2;
  localparam logic [POS_W-1:0] POS_DATA2    = 3'd3;
  localparam logic [POS_W-1:0] POS_DATA3    = 3'd4;
  localparam logic [POS_W-1:0] POS_CHECKSUM = 3'd5;
  localparam logic [POS_W-1:0] POS_STOP     = 3'd6;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] type_code_power;
    logic [BYTE_W-1:0] type_code_level;
    logic [BYTE_W-1:0] type_code_colour;
  } cfg_t;

  typedef struct packed {
    kind_t             command_kind;
    logic [BYTE_W-1:0] power_value;
    logic [BYTE_W-1:0] level_value;
    logic [BYTE_W-1:0] red_value;
    logic [BYTE_W-1:0] green_value;
    logic [BYTE_W-1:0] blue_value;
    logic              checksum_ok;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/lcfp_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcfp_cfg_regs
// Holds the start marker and the three type codes; write-only port.
// ----------------------------------------------------------------------------
module lcfp_cfg_regs
  import lcfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker     <= 8'd0;
      cfg.type_code_power  <= 8'd1;
      cfg.type_code_level  <= 8'd2;
      cfg.type_code_colour <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_START_MARKER:     cfg.start_marker     <= cfg_wdata;
        CFG_TYPE_CODE_POWER:  cfg.type_code_power  <= cfg_wdata;
        CFG_TYPE_CODE_LEVEL:  cfg.type_code_level  <= cfg_wdata;
        CFG_TYPE_CODE_COLOUR: cfg.type_code_colour <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/lcfp_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcfp_parser
// Frame state, running sum and kept value registers; one byte per step.
// ----------------------------------------------------------------------------
module lcfp_parser
  import lcfp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output logic                   produced,
  output result_t                result
);

  logic              in_frame;
  logic [POS_W-1:0]  byte_position;
  logic [BYTE_W-1:0] running_sum;
  logic              sum_matched;
  logic [BYTE_W-1:0] frame_type;
  logic [BYTE_W-1:0] power_reg;
  logic [BYTE_W-1:0] level_reg;
  logic [BYTE_W-1:0] red_reg;
  logic [BYTE_W-1:0] green_reg;
  logic [BYTE_W-1:0] blue_reg;
  kind_t             kind;
  logic [BYTE_W-1:0] sum_add;

  // Power wins over level, level over colour
  always_comb begin
    if (frame_type == cfg.type_code_power)       kind = KIND_POWER;
    else if (frame_type == cfg.type_code_level)  kind = KIND_LEVEL;
    else if (frame_type == cfg.type_code_colour) kind = KIND_COLOUR;
    else                                         kind = KIND_NONE;
  end

  assign sum_add = running_sum + rx_byte;

  assign produced = step && in_frame && (byte_position == POS_STOP) && (kind != KIND_NONE);

  always_comb begin
    result.command_kind = kind;
    result.power_value  = power_reg;
    result.level_value  = level_reg;
    result.red_value    = red_reg;
    result.green_value  = green_reg;
    result.blue_value   = blue_reg;
    result.checksum_ok  = sum_matched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_position <= '0;
      running_sum   <= '0;
      sum_matched   <= 1'b1;
      frame_type    <= '0;
      power_reg     <= '0;
      level_reg     <= '0;
      red_reg       <= '0;
      green_reg     <= '0;
      blue_reg      <= '0;
    end else if (step) begin
      if (!in_frame) begin
        // Hunt: the marker opens a frame and takes position 0
        if (rx_byte == cfg.start_marker) begin
          in_frame      <= 1'b1;
          byte_position <= POS_TYPE;
        end
      end else begin
        byte_position <= byte_position + 3'd1;
        case (byte_position)
          POS_TYPE: begin
            frame_type  <= rx_byte;
            running_sum <= sum_add;
          end
          POS_DATA1: begin
            running_sum <= sum_add;
            if (kind == KIND_POWER)       power_reg <= rx_byte;
            else if (kind == KIND_LEVEL)  level_reg <= rx_byte;
            else if (kind == KIND_COLOUR) red_reg   <= rx_byte;
          end
          POS_DATA2: begin
            running_sum <= sum_add;
            if (kind == KIND_COLOUR) green_reg <= rx_byte;
          end
          POS_DATA3: begin
            running_sum <= sum_add;
            if (kind == KIND_COLOUR) blue_reg <= rx_byte;
          end
          POS_CHECKSUM: begin
            sum_matched <= (rx_byte == running_sum);
            running_sum <= '0;
          end
          POS_STOP: begin
            in_frame <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/light_command_frame_parser_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// light_command_frame_parser_top
// Start-byte framed light command parser with additive checksum.
// ----------------------------------------------------------------------------
// One received byte enters per input beat. While hunting, bytes other than
// the start marker are dropped. After the marker the next six bytes are the
// type, three data bytes, the checksum and the stop byte (stop value is not
// checked). Type and data bytes are summed modulo 256; the checksum byte is
// compared with that sum, which then clears. The data bytes update the kept
// power, level or red/green/blue registers as the type selects. On the stop
// byte one result beat carries the command kind, all kept values and the
// kept checksum flag; a frame with an unknown type gives no result beat.
// Rate: one byte per clock unless the output stalls. Each byte passes an
// input register, decode and state update, and an output register; the
// result beat of a stop byte is loaded into the output register. The output
// register only stalls the input when a result is held and m_tready is low.
// Configuration writes take effect on the next clock; write them only while
// the block is idle.
// ----------------------------------------------------------------------------
module light_command_frame_parser_top
  import lcfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  // byte input
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
  // command output
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [39:0]               m_tdata,   // [7:0] power_value, [15:8] level_value,
                                               // [23:16] red_value, [31:24] green_value,
                                               // [39:32] blue_value
  output logic [2:0]                m_tuser    // [1:0] command_kind, [2] checksum_ok
);

  cfg_t              cfg;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  logic              produced;
  result_t           result;

  lcfp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Process the held byte whenever the output register is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register: hold the beat until it is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  lcfp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .step     (advance),
    .rx_byte  (in_byte),
    .produced (produced),
    .result   (result)
  );

  // Output register: load a new result, or drop the one just taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= produced;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produced) begin
      m_tdata <= {result.blue_value, result.green_value, result.red_value,
                  result.level_value, result.power_value};
      m_tuser <= {result.checksum_ok, result.command_kind};
    end
  end

endmodule
`default_nettype wire

// ----- sv/lcfp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcfp_checker
// Port-level checks of the light command frame parser, bound to the top.
// ----------------------------------------------------------------------------
module lcfp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  // A stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  // Never a result with the unknown kind
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[1:0] != 2'd3))
    else $error("result beat with unknown kind");

  // Input is only held back by a waiting result
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // A new result follows an earlier accepted input beat
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result beat without an input beat");

  // No result right after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat after reset");

endmodule

bind light_command_frame_parser_top lcfp_checker u_lcfp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

// ----- tb/light_command_frame_parser_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_command_frame_parser_checker
// Watches the byte, command and register channels of the frame parser, keeps
// its own copy of the parser state, and compares every command beat against
// the oldest predicted command.
// ----------------------------------------------------------------------------
module light_command_frame_parser_checker
  import lcfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
  input  wire logic                 m_tvalid,
  input  wire logic                 m_tready,
  input  wire logic [39:0]          m_tdata,   // [7:0] power, [15:8] level, [23:16] red,
                                               // [31:24] green, [39:32] blue
  input  wire logic [2:0]           m_tuser,   // [1:0] command_kind, [2] checksum_ok
  output int                        fail_count,
  output int                        cmds_waiting
);

  cfg_t              regs;
  logic              in_frame;
  logic [POS_W-1:0]  pos;
  logic [BYTE_W-1:0] byte_sum;
  logic              sum_good;
  logic [BYTE_W-1:0] frame_type;
  logic [BYTE_W-1:0] power_q, level_q, red_q, green_q, blue_q;
  result_t           expected_cmds[$];

  // Power code wins over level, level over colour.
  function automatic kind_t decode_type(input logic [BYTE_W-1:0] t);
    if (t == regs.type_code_power)  return KIND_POWER;
    if (t == regs.type_code_level)  return KIND_LEVEL;
    if (t == regs.type_code_colour) return KIND_COLOUR;
    return KIND_NONE;
  endfunction

  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    kind_t   k;
    result_t cmd;
    if (!in_frame) begin
      if (b != regs.start_marker) return;
      in_frame = 1'b1;
      pos      = '0;
    end
    k = decode_type(frame_type);
    case (pos)
      POS_TYPE: begin
        frame_type = b;
        byte_sum   = byte_sum + b;
      end
      POS_DATA1: begin
        case (k)
          KIND_POWER:  power_q = b;
          KIND_LEVEL:  level_q = b;
          KIND_COLOUR: red_q   = b;
          default: ;
        endcase
        byte_sum = byte_sum + b;
      end
      POS_DATA2: begin
        if (k == KIND_COLOUR) green_q = b;
        byte_sum = byte_sum + b;
      end
      POS_DATA3: begin
        if (k == KIND_COLOUR) blue_q = b;
        byte_sum = byte_sum + b;
      end
      POS_CHECKSUM: begin
        sum_good = (b == byte_sum);
        byte_sum = '0;
      end
      POS_STOP: begin
        in_frame = 1'b0;
        if (k != KIND_NONE) begin
          cmd.command_kind = k;
          cmd.power_value  = power_q;
          cmd.level_value  = level_q;
          cmd.red_value    = red_q;
          cmd.green_value  = green_q;
          cmd.blue_value   = blue_q;
          cmd.checksum_ok  = sum_good;
          expected_cmds.push_back(cmd);
        end
      end
      default: ;
    endcase
    pos = pos + 3'd1;
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t exp_cmd;
    result_t got_cmd;
    if (rst) begin
      regs       = '{start_marker: 8'h00, type_code_power: 8'h01,
                     type_code_level: 8'h02, type_code_colour: 8'h03};
      in_frame   = 1'b0;
      pos        = '0;
      byte_sum   = '0;
      sum_good   = 1'b1;
      frame_type = '0;
      power_q    = '0;
      level_q    = '0;
      red_q      = '0;
      green_q    = '0;
      blue_q     = '0;
      expected_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_START_MARKER:     regs.start_marker     = cfg_wdata;
          CFG_TYPE_CODE_POWER:  regs.type_code_power  = cfg_wdata;
          CFG_TYPE_CODE_LEVEL:  regs.type_code_level  = cfg_wdata;
          CFG_TYPE_CODE_COLOUR: regs.type_code_colour = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) parse_rx_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        got_cmd.command_kind = kind_t'(m_tuser[1:0]);
        got_cmd.checksum_ok  = m_tuser[2];
        got_cmd.power_value  = m_tdata[7:0];
        got_cmd.level_value  = m_tdata[15:8];
        got_cmd.red_value    = m_tdata[23:16];
        got_cmd.green_value  = m_tdata[31:24];
        got_cmd.blue_value   = m_tdata[39:32];
        if (expected_cmds.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected command beat, expected none, actual %0h/%0h",
                   $time, m_tuser, m_tdata);
        end else begin
          exp_cmd = expected_cmds.pop_front();
          check_field("command_kind", 8'(exp_cmd.command_kind), 8'(got_cmd.command_kind));
          check_field("power_value", exp_cmd.power_value, got_cmd.power_value);
          check_field("level_value", exp_cmd.level_value, got_cmd.level_value);
          check_field("red_value", exp_cmd.red_value, got_cmd.red_value);
          check_field("green_value", exp_cmd.green_value, got_cmd.green_value);
          check_field("blue_value", exp_cmd.blue_value, got_cmd.blue_value);
          check_field("checksum_ok", 8'(exp_cmd.checksum_ok), 8'(got_cmd.checksum_ok));
        end
      end
    end
    cmds_waiting = expected_cmds.size();
  end

endmodule

// ----- tb/light_command_frame_parser_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_command_frame_parser_top_tb
// Drives received bytes and register writes into the frame parser and gives
// the verdict. A directed run covers the field extremes, the power and colour
// kinds, a bad checksum, an unknown type and a dropped hunting byte; then random
// phases send mostly well-formed frames with random content, mixed with noise
// and cut-off frames, under several register settings with random idling on
// both sides outside the calm phases. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module light_command_frame_parser_top_tb;
  import lcfp_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. The
  // slowest correct gap is a sender idle plus a receiver stall plus the
  // pipeline and register writes.
  localparam int IDLE_LIMIT = 1000;
  // Pipeline depth plus margin, so the beat of a final stop byte can come out.
  localparam int SETTLE_CYCLES = 8;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;    // [7:0] rx_byte
  logic                 m_tvalid;
  logic                 m_tready;
  logic [39:0]          m_tdata;    // [7:0] power, [15:8] level, [23:16] red,
                                    // [31:24] green, [39:32] blue
  logic [2:0]           m_tuser;    // [1:0] command_kind, [2] checksum_ok

  int fail_count;
  int cmds_waiting;
  int idle_cycles;
  int bytes_sent;
  bit calm;       // no idling on either side while set

  // Stimulus-side copy of the register settings, used to build frames
  logic [7:0] marker, code_power, code_level, code_colour;

  light_command_frame_parser_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  light_command_frame_parser_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .fail_count   (fail_count),
    .cmds_waiting (cmds_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // Hang detection: count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver: stall a random number of cycles, then hold ready until a beat
  // is taken. Ready stays high across back-to-back beats when the draw is 0.
  initial begin : command_sink
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        @(negedge clk);
        m_tready = 1'b0;
      end
      @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Offer one byte after a random gap; hold it until the beat is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] d1,
                            input logic [7:0] d2, input logic [7:0] d3,
                            input bit good_sum);
    logic [7:0] sum;
    sum = ftype + d1 + d2 + d3;
    if (!good_sum) sum = sum + 8'($urandom_range(1, 255));
    send_byte(marker);
    send_byte(ftype);
    send_byte(d1);
    send_byte(d2);
    send_byte(d3);
    send_byte(sum);
    send_byte(8'($urandom_range(0, 255)));  // stop value is not checked
  endtask

  // Six non-marker bytes close any open frame and leave the parser hunting.
  task automatic flush_frame();
    repeat (6) send_byte(8'(marker + 8'd1));
  endtask

  // Drop valid and hold off until every predicted command has come out.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (cmds_waiting != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] m, input logic [7:0] p,
                            input logic [7:0] l, input logic [7:0] c);
    write_reg(CFG_START_MARKER, m);
    write_reg(CFG_TYPE_CODE_POWER, p);
    write_reg(CFG_TYPE_CODE_LEVEL, l);
    write_reg(CFG_TYPE_CODE_COLOUR, c);
    marker      = m;
    code_power  = p;
    code_level  = l;
    code_colour = c;
  endtask

  // Mostly well-formed frames with random content; some noise, some cut-off
  // frames, and an occasional full pause until the output side is empty.
  task automatic run_random(input int count);
    int first;
    int pick;
    logic [7:0] ftype;
    first = bytes_sent;
    while (bytes_sent - first < count) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        flush_frame();
      end else if (pick == 1) begin
        send_byte(marker);
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
        flush_frame();
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 3)      ftype = code_power;
        else if (pick < 6) ftype = code_level;
        else if (pick < 9) ftype = code_colour;
        else               ftype = 8'($urandom_range(0, 255));
        send_frame(ftype, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = CFG_START_MARKER;
    cfg_wdata   = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    calm        = 1'b0;
    bytes_sent  = 0;
    idle_cycles = 0;
    marker      = 8'h00;
    code_power  = 8'h01;
    code_level  = 8'h02;
    code_colour = 8'h03;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: a byte dropped while hunting, a power frame with full-scale
    // data, a colour frame with a bad checksum, and an unknown type that
    // gives no beat but still updates the checksum flag.
    send_byte(8'hFF);
    send_frame(code_power, 8'hFF, 8'h00, 8'hFF, 1'b1);
    send_frame(code_colour, 8'h00, 8'hFF, 8'h55, 1'b0);
    send_frame(8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: ;  // keep the reset settings
        1: set_config(8'hFF, 8'h00, 8'h7F, 8'h80);
        2: set_config(8'hA5, 8'h10, 8'h10, 8'h10);  // power wins over all
        3: set_config(8'h00, 8'h01, 8'hFE, 8'hFE);  // level wins over colour
        default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      calm = (ph == 2 || ph == 5);
      run_random(230);
      flush_frame();
      drain();
      // An unknown-type frame leaves nothing to wait on; let the pipe empty.
      repeat (SETTLE_CYCLES) @(negedge clk);
    end

    calm = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && cmds_waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
